[rtl/bfra_pkg.sv]
// Package for the best-fit range allocator: request/result structs, codes.
// No dependencies.
package bfra_pkg;

	// slots the heap can ever hold; heap_size writes clamp to this
	localparam int MAX_SLOTS = 1024;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FAIL = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [0:0]  cmd;
		logic [10:0] count;
		logic [9:0]  range_start;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot_offset;
		logic [10:0] free_total;
	} rsp_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_APPLY,
		FSM_OUT
	} fsm_t;

endpackage

[rtl/bfra_cell.sv]
// One segment-table entry of the allocator chain.
// Depends on bfra_pkg.
module bfra_cell import bfra_pkg::*; #(
	parameter int SW = 10,
	parameter int LW = 11,
	parameter logic          RST_VALID = 1'b0,
	parameter logic [LW-1:0] RST_LEN   = '0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          init,
	input  logic          init_first,
	input  logic [LW-1:0] init_len,
	input  logic          shift,
	input  logic          in_valid,
	input  logic [SW-1:0] in_start,
	input  logic [LW-1:0] in_len,
	input  logic          wr,
	input  logic          wr_valid,
	input  logic [SW-1:0] wr_start,
	input  logic [LW-1:0] wr_len,
	output logic          valid,
	output logic [SW-1:0] start,
	output logic [LW-1:0] len
);
	logic          valid_q;
	logic [SW-1:0] start_q;
	logic [LW-1:0] len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= RST_VALID;
			start_q <= '0;
			len_q   <= RST_LEN;
		end else if (init) begin
			valid_q <= init_first;
			start_q <= '0;
			len_q   <= init_first ? init_len : '0;
		end else if (wr) begin
			valid_q <= wr_valid;
			start_q <= wr_start;
			len_q   <= wr_len;
		end else if (shift) begin
			valid_q <= in_valid;
			start_q <= in_start;
			len_q   <= in_len;
		end
	end

	assign valid = valid_q;
	assign start = start_q;
	assign len   = len_q;
endmodule

[rtl/best_fit_range_allocator.sv]
// Best-fit range allocator top level: rotating chain of segment cells plus
// a scan/apply controller. Depends on bfra_pkg and bfra_cell.
//
// The free table is a ring of MAX_SEGMENTS cells that rotates one entry per
// cycle while a request is scanned or applied; the head cell is examined each
// cycle of a rotation. After reset entry zero holds one segment covering the
// whole heap. A request runs in four phases: the accept cycle, one full
// rotation to scan (best fit, or overlap and neighbors on a free), a second
// full rotation that rewrites the chosen entries as they pass the head, then
// the OUT state that finishes loading the result. The result is presented in
// the following cycle. A heap_size write reloads the table (one segment at
// offset 0, or none for a zero size).
// Results wait in an output register until taken; no new request is taken
// while a result is pending.
module best_fit_range_allocator import bfra_pkg::*; #(
	parameter int MAX_SEGMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output rsp_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data
);
	localparam int SW = 10;
	localparam int LW = 11;
	localparam int NW = $clog2(MAX_SEGMENTS);
	localparam logic [LW:0] MAXS = (MAX_SLOTS > 2047) ? 12'd2047 : 12'(MAX_SLOTS);
	localparam logic [LW-1:0] RST_HEAP = LW'(MAX_SLOTS > 1024 ? 1024 : MAX_SLOTS);

	fsm_t state_q, state_d;
	logic [NW-1:0] pos_q;       // index of entry at head
	logic          wrap_q;
	req_t          req_q;
	logic [LW-1:0] heap_q, free_q;
	rsp_t          rsp_q;
	status_t       st_c;        // outcome, valid once the scan rotation is done
	// scan results, by entry index
	logic          best_v_q, low_v_q, up_v_q, emp_v_q, ovl_q;
	logic [NW-1:0] best_i_q, low_i_q, up_i_q, emp_i_q;
	logic [SW-1:0] best_s_q;
	logic [LW-1:0] best_l_q, up_l_q;

	logic          h_valid [MAX_SEGMENTS];
	logic [SW-1:0] h_start [MAX_SEGMENTS];
	logic [LW-1:0] h_len   [MAX_SEGMENTS];
	logic          wr_c;
	logic          wr_v;
	logic [SW-1:0] wr_s;
	logic [LW-1:0] wr_l;
	logic          shift, init;
	logic [LW-1:0] eff;

	assign eff = ({1'b0, cfg_data} > MAXS) ? MAXS[LW-1:0] : cfg_data;
	assign init = cfg_valid && cfg_ready;
	assign cfg_ready = (state_q == FSM_IDLE) && !out_valid;
	assign shift = (state_q == FSM_SCAN) || (state_q == FSM_APPLY);

	genvar g;
	generate
		for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
			localparam int NX = (g + 1) % MAX_SEGMENTS;
			bfra_cell #(
				.SW(SW), .LW(LW),
				.RST_VALID(g == 0),
				.RST_LEN(g == 0 ? RST_HEAP : '0)
			) u_cell (
				.clk, .arst_n, .init,
				.init_first(g == 0 && eff != '0),
				.init_len(eff),
				.shift,
				.in_valid(h_valid[NX]), .in_start(h_start[NX]), .in_len(h_len[NX]),
				.wr(g == MAX_SEGMENTS - 1 && wr_c),
				.wr_valid(wr_v), .wr_start(wr_s), .wr_len(wr_l),
				.valid(h_valid[g]), .start(h_start[g]), .len(h_len[g])
			);
		end
	endgenerate

	// head = cell 0; after a shift it lands in the last cell with update
	logic [LW:0] hend, rend;
	assign hend = {1'b0, h_start[0]} + {1'b0, h_len[0]};
	assign rend = {2'b0, req_q.range_start} + {1'b0, req_q.count};

	always_comb begin
		wr_c = 1'b0;
		wr_v = h_valid[0];
		wr_s = h_start[0];
		wr_l = h_len[0];
		if (state_q == FSM_APPLY && st_c == ST_OK) begin
			if (req_q.cmd == CMD_ALLOC) begin
				if (pos_q == best_i_q) begin
					wr_c = 1'b1;
					wr_v = (best_l_q != req_q.count);
					wr_s = wr_v ? (best_s_q + req_q.count[SW-1:0]) : '0;
					wr_l = wr_v ? (best_l_q - req_q.count) : '0;
				end
			end else if (low_v_q) begin
				if (pos_q == low_i_q) begin
					wr_c = 1'b1;
					wr_l = h_len[0] + req_q.count + (up_v_q ? up_l_q : '0);
				end else if (up_v_q && pos_q == up_i_q) begin
					wr_c = 1'b1; wr_v = 1'b0; wr_s = '0; wr_l = '0;
				end
			end else if (up_v_q) begin
				if (pos_q == up_i_q) begin
					wr_c = 1'b1;
					wr_s = req_q.range_start;
					wr_l = h_len[0] + req_q.count;
				end
			end else if (pos_q == emp_i_q) begin
				wr_c = 1'b1; wr_v = 1'b1;
				wr_s = req_q.range_start;
				wr_l = req_q.count;
			end
		end
	end

	// outcome from the complete scan; held steady through the apply rotation
	always_comb begin
		st_c = ST_OK;
		if (req_q.cmd == CMD_ALLOC) begin
			if (req_q.count == '0 || req_q.count > free_q || !best_v_q)
				st_c = ST_FAIL;
		end else if (req_q.count == '0 || rend > {1'b0, heap_q} || ovl_q) begin
			st_c = ST_FAIL;
		end else if (!low_v_q && !up_v_q && !emp_v_q) begin
			st_c = ST_FULL;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE:  if (in_valid && !in_stall) state_d = FSM_SCAN;
			FSM_SCAN:  if (wrap_q) state_d = FSM_APPLY;
			FSM_APPLY: if (wrap_q) state_d = FSM_OUT;
			FSM_OUT:   state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
	end

	assign in_stall = (state_q != FSM_IDLE) || out_valid;
	logic out_v_q;
	assign out_valid = out_v_q;
	assign out_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			out_v_q <= 1'b0;
			heap_q  <= RST_HEAP;
			free_q  <= RST_HEAP;
			pos_q   <= '0;
			wrap_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_v_q && !out_stall) out_v_q <= 1'b0;
			if (init) begin
				heap_q <= eff;
				free_q <= eff;
			end
			if (shift) begin
				pos_q  <= (pos_q == NW'(MAX_SEGMENTS - 1)) ? '0 : pos_q + 1'b1;
				wrap_q <= (pos_q == NW'(MAX_SEGMENTS - 2));
			end else begin
				wrap_q <= 1'b0;
			end
			if (state_q == FSM_APPLY && wrap_q) begin
				rsp_q.status      <= st_c;
				rsp_q.slot_offset <= (req_q.cmd == CMD_ALLOC && st_c == ST_OK) ?
					best_s_q : '0;
				if (st_c == ST_OK) begin
					if (req_q.cmd == CMD_ALLOC) free_q <= free_q - req_q.count;
					else free_q <= free_q + req_q.count;
				end
			end
			if (state_q == FSM_OUT) begin
				out_v_q <= 1'b1;
				rsp_q.free_total <= free_q;
			end
		end
	end

	// request capture and scan datapath
	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && in_valid && !in_stall) begin
			req_q    <= in_data;
			best_v_q <= 1'b0;
			low_v_q  <= 1'b0;
			up_v_q   <= 1'b0;
			emp_v_q  <= 1'b0;
			ovl_q    <= 1'b0;
		end else if (state_q == FSM_SCAN) begin
			if (!h_valid[0]) begin
				if (!emp_v_q) begin
					emp_v_q <= 1'b1;
					emp_i_q <= pos_q;
				end
			end else begin
				if (h_len[0] >= req_q.count && (!best_v_q || h_len[0] < best_l_q ||
					(h_len[0] == best_l_q && h_start[0] < best_s_q))) begin
					best_v_q <= 1'b1;
					best_i_q <= pos_q;
					best_l_q <= h_len[0];
					best_s_q <= h_start[0];
				end
				if ({2'b0, req_q.range_start} < hend && {2'b0, h_start[0]} < rend)
					ovl_q <= 1'b1;
				if (hend == {2'b0, req_q.range_start}) begin
					low_v_q <= 1'b1;
					low_i_q <= pos_q;
				end
				if ({2'b0, h_start[0]} == rend) begin
					up_v_q <= 1'b1;
					up_i_q <= pos_q;
					up_l_q <= h_len[0];
				end
			end
		end
	end
endmodule

[verif/bfra_checker.sv]
// Checker for the best-fit range allocator: watches request, result and
// heap_size channels, predicts each result and compares. Depends on bfra_pkg.
module bfra_checker import bfra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  req_t        in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  rsp_t        out_data,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	localparam int NSEG = 64;
	localparam int NSLOT = 1024;

	logic [10:0] heap_words;
	logic [9:0]  seg_lo [NSEG];
	logic [10:0] seg_len [NSEG];
	logic        seg_on [NSEG];
	logic [10:0] free_left;
	rsp_t        rsp_queue [$];

	function automatic int eff_heap();
		return (heap_words > NSLOT) ? NSLOT : int'(heap_words);
	endfunction

	function automatic void reload_table();
		int e;
		e = eff_heap();
		for (int i = 0; i < NSEG; i++) begin
			seg_lo[i] = '0;
			seg_len[i] = '0;
			seg_on[i] = 1'b0;
		end
		if (e > 0) begin
			seg_len[0] = 11'(e);
			seg_on[0] = 1'b1;
		end
		free_left = 11'(e);
	endfunction

	function automatic rsp_t allocate(int cnt);
		rsp_t r;
		int best;
		best = -1;
		r = '0;
		r.status = ST_FAIL;
		if (cnt == 0 || cnt > free_left) begin
			r.free_total = free_left;
			return r;
		end
		for (int i = 0; i < NSEG; i++) begin
			if (!seg_on[i] || seg_len[i] < cnt)
				continue;
			if (best < 0 || seg_len[i] < seg_len[best] ||
					(seg_len[i] == seg_len[best] && seg_lo[i] < seg_lo[best]))
				best = i;
		end
		if (best >= 0) begin
			r.status = ST_OK;
			r.slot_offset = seg_lo[best];
			if (seg_len[best] == cnt) begin
				seg_on[best] = 1'b0;
				seg_lo[best] = '0;
				seg_len[best] = '0;
			end else begin
				seg_lo[best] = 10'(seg_lo[best] + cnt);
				seg_len[best] = 11'(seg_len[best] - cnt);
			end
			free_left = 11'(free_left - cnt);
		end
		r.free_total = free_left;
		return r;
	endfunction

	function automatic status_t release_range(int lo, int cnt);
		int hi, below, above, hole;
		hi = lo + cnt;
		below = -1;
		above = -1;
		hole = -1;
		if (cnt == 0 || hi > eff_heap())
			return ST_FAIL;
		for (int i = 0; i < NSEG; i++) begin
			if (!seg_on[i]) begin
				if (hole < 0)
					hole = i;
				continue;
			end
			if (lo < seg_lo[i] + seg_len[i] && seg_lo[i] < hi)
				return ST_FAIL;
			if (seg_lo[i] + seg_len[i] == lo)
				below = i;
			if (seg_lo[i] == hi)
				above = i;
		end
		if (below >= 0 && above >= 0) begin
			seg_len[below] = 11'(seg_len[below] + cnt + seg_len[above]);
			seg_on[above] = 1'b0;
			seg_lo[above] = '0;
			seg_len[above] = '0;
		end else if (below >= 0) begin
			seg_len[below] = 11'(seg_len[below] + cnt);
		end else if (above >= 0) begin
			seg_lo[above] = 10'(lo);
			seg_len[above] = 11'(seg_len[above] + cnt);
		end else if (hole >= 0) begin
			seg_on[hole] = 1'b1;
			seg_lo[hole] = 10'(lo);
			seg_len[hole] = 11'(cnt);
		end else begin
			return ST_FULL;
		end
		free_left = 11'(free_left + cnt);
		return ST_OK;
	endfunction

	assign pending = rsp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t r, got;
		if (!arst_n) begin
			heap_words = 11'd1024;
			reload_table();
			rsp_queue.delete();
			fail_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = out_data;
				if (rsp_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %p", got);
					fail_count <= fail_count + 1;
				end else begin
					r = rsp_queue.pop_front();
					if (got.status !== r.status || got.slot_offset !== r.slot_offset ||
							got.free_total !== r.free_total) begin
						if (fail_count < 10)
							$display("mismatch: expected %p got %p", r, got);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				heap_words = cfg_data;
				reload_table();
			end
			if (in_valid && !in_stall) begin
				if (in_data.cmd == CMD_ALLOC) begin
					r = allocate(int'(in_data.count));
				end else begin
					r = '0;
					r.status = release_range(int'(in_data.range_start), int'(in_data.count));
					r.free_total = free_left;
				end
				rsp_queue.push_back(r);
			end
		end
	end
endmodule

[verif/tb_best_fit_range_allocator.sv]
// Testbench top for the best-fit range allocator: clock, reset, request and
// heap_size stimulus, result stall pattern, verdict. Depends on bfra_pkg,
// bfra_checker and the block itself.
module tb_best_fit_range_allocator;
	import bfra_pkg::*;

	// watchdog limit, sized for a full request plus stall and gap slack
	localparam int IDLE_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	req_t        in_data;
	logic        out_valid;
	logic        out_stall;
	rsp_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;
	int          fail_count;
	int          pending;
	int          quiet_cycles;
	logic        stall_heavy;

	// ranges we hold, so frees usually return real allocations
	logic [9:0]  held_lo [$];
	logic [10:0] held_len [$];
	int          heap_now;

	best_fit_range_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	bfra_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver stall: alternates between calm and heavy stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_heavy <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_heavy <= ~stall_heavy;
			out_stall <= stall_heavy ? ($urandom_range(0, 3) != 0)
				: ($urandom_range(0, 7) == 0);
		end
	end

	// Watchdog: counts cycles with no handshake of any kind.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > IDLE_LIMIT) begin
			$display("[best_fit_range_allocator] ERROR");
			$finish;
		end
	end

	// One request; valid stays high across back-to-back requests of a burst.
	task automatic send(input cmd_t c, input int cnt, input int lo, input bit hold);
		in_valid <= 1'b1;
		in_data <= '{cmd: c, count: 11'(cnt), range_start: 10'(lo)};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!hold)
			in_valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (140) @(posedge clk);
	endtask

	task automatic write_heap(input int sz);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= 11'(sz);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		held_lo.delete();
		held_len.delete();
		heap_now = (sz > 1024) ? 1024 : sz;
	endtask

	// Allocate or free with random content; track successes loosely by
	// remembering the offsets we would get (the checker is the authority).
	task automatic random_request(input bit hold);
		int k, cnt, lo;
		k = $urandom_range(0, 99);
		if (k < 45) begin
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
				: $urandom_range(1, 40);
			send(CMD_ALLOC, cnt, $urandom_range(0, 1023), hold);
		end else if (k < 85 && held_lo.size() > 0) begin
			// free part or all of a range we allocated earlier
			k = $urandom_range(0, held_lo.size() - 1);
			send(CMD_FREE, held_len[k], held_lo[k], hold);
			held_lo.delete(k);
			held_len.delete(k);
		end else begin
			// noise: arbitrary frees, overlaps, past the end, zero
			cnt = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 8);
			lo = $urandom_range(0, 1023);
			send(CMD_FREE, cnt, lo, hold);
		end
	endtask

	// Shadow of successful allocations, fed from the result stream.
	req_t last_reqs [$];
	always @(posedge clk) begin
		req_t q;
		if (arst_n && in_valid && !in_stall)
			last_reqs.push_back(in_data);
		if (arst_n && out_valid && !out_stall && last_reqs.size() > 0) begin
			q = last_reqs.pop_front();
			if (q.cmd == CMD_ALLOC && out_data.status == ST_OK) begin
				// split some ranges so frees come back in pieces
				if (q.count > 1 && $urandom_range(0, 2) == 0) begin
					held_lo.push_back(out_data.slot_offset);
					held_len.push_back(q.count / 2);
					held_lo.push_back(10'(out_data.slot_offset + q.count / 2));
					held_len.push_back(q.count - q.count / 2);
				end else begin
					held_lo.push_back(out_data.slot_offset);
					held_len.push_back(q.count);
				end
			end
		end
	end

	initial begin
		int burst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		heap_now = 1024;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, zero counts, too large, overlap, past end
		send(CMD_ALLOC, 0, 0, 0);
		send(CMD_ALLOC, 2047, 1023, 0);
		send(CMD_ALLOC, 1024, 0, 0);
		send(CMD_ALLOC, 1, 0, 0);
		send(CMD_FREE, 1024, 0, 0);
		send(CMD_FREE, 1, 1023, 1);
		send(CMD_FREE, 0, 5, 0);
		send(CMD_FREE, 1024, 0, 0);
		send(CMD_FREE, 1023, 1, 0);
		send(CMD_FREE, 1, 0, 0);
		send(CMD_ALLOC, 3, 0, 0);
		send(CMD_ALLOC, 5, 0, 0);
		send(CMD_ALLOC, 7, 0, 0);
		send(CMD_FREE, 5, 3, 0);
		send(CMD_FREE, 3, 0, 0);
		send(CMD_FREE, 7, 8, 0);
		// table full: 64 isolated holes then one more
		write_heap(130);
		repeat (65) send(CMD_ALLOC, 2, 0, 1);
		in_valid <= 1'b0;
		for (int i = 0; i < 65; i++)
			send(CMD_FREE, 1, 2 * i, 1);
		in_valid <= 1'b0;
		write_heap(0);
		send(CMD_ALLOC, 1, 0, 0);
		send(CMD_FREE, 1, 0, 0);
		write_heap(2047);
		send(CMD_FREE, 1, 1023, 0);
		write_heap(1);
		send(CMD_ALLOC, 1, 0, 0);
		send(CMD_FREE, 1, 0, 0);
		write_heap(1024);

		// random phases with heap resizes between them
		for (int ph = 0; ph < 5; ph++) begin
			for (int n = 0; n < 160; n++) begin
				burst = $urandom_range(1, 8);
				random_request(burst > 1 && n % burst != 0);
				if (n % burst == 0) begin
					in_valid <= 1'b0;
					repeat ($urandom_range(0, 150)) @(posedge clk);
				end
				if (n == 80) begin
					// wait for every result before going on
					in_valid <= 1'b0;
					@(posedge clk);
					while (pending != 0)
						@(posedge clk);
				end
			end
			in_valid <= 1'b0;
			case (ph)
				0: write_heap($urandom_range(1, 200));
				1: write_heap(1024);
				2: write_heap($urandom_range(1025, 2047));
				3: write_heap($urandom_range(60, 300));
				default: write_heap($urandom_range(1, 1024));
			endcase
		end

		drain();
		if (fail_count == 0)
			$display("[best_fit_range_allocator] OK");
		else
			$display("[best_fit_range_allocator] ERROR");
		$finish;
	end
endmodule

[best_fit_range_allocator.f]
rtl/bfra_pkg.sv
rtl/bfra_cell.sv
rtl/best_fit_range_allocator.sv
verif/bfra_checker.sv
verif/tb_best_fit_range_allocator.sv
